### rtl/tap_tempo_estimator_macros.svh
// Assertion macros for the tap tempo estimator.
// Included by the modules that check their own control logic; no other dependency.
`ifndef TAP_TEMPO_ESTIMATOR_MACROS_SVH
`define TAP_TEMPO_ESTIMATOR_MACROS_SVH

`ifndef SYNTH
// Checks prop on every rising clock edge outside reset.
`define TTE_ASSERT(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("tap tempo estimator check failed");
// Checks that cond implies res on the same edge.
`define TTE_ASSERT_IMPL(name, cond, res) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |-> (res)) \
    else $error("tap tempo estimator check failed");
`else
`define TTE_ASSERT(name, prop)
`define TTE_ASSERT_IMPL(name, cond, res)
`endif

`endif

### rtl/tte_pkg.sv
// Shared constants, widths and request/response types of the tap tempo estimator.
// Used by the serial multiplier, the serial divider and the top level.
package tte_pkg;

  localparam int COUNT_BITS    = 16;
  localparam int FRACTION_BITS = 8;

  localparam int TIME_W   = 32;
  localparam int REG_W    = 11;
  localparam int TEMPO_W  = 12;
  localparam int PERIOD_W = 16;
  localparam int TAPS_W   = 16;

  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_INTERVAL = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_INTERVAL = 1'b1;
  localparam logic [REG_W-1:0] MIN_INTERVAL_RESET = 11'd214;
  localparam logic [REG_W-1:0] MAX_INTERVAL_RESET = 11'd1200;

  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 48;

  localparam longint unsigned MS_PER_MINUTE = 60000;
  localparam longint unsigned TEMPO_MAX     = 4095;
  localparam longint unsigned TAPS_MAX      = 65535;

  // Average in fixed point: integer part as wide as an interval register.
  localparam int AVG_W  = REG_W + FRACTION_BITS;
  localparam int PROD_W = AVG_W + COUNT_BITS;
  localparam int SUM_W  = PROD_W + 1;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  // Tempo numerator: 2 * 60000 * 2^FRACTION_BITS + average.
  localparam longint unsigned TNUM_BASE = (2 * MS_PER_MINUTE) << FRACTION_BITS;
  localparam longint unsigned TNUM_MAX  = TNUM_BASE + (64'd1 << AVG_W) - 1;
  localparam int TNUM_W = $clog2(TNUM_MAX + 1);

  localparam int NUM_W0 = (SUM_W > TNUM_W) ? SUM_W : TNUM_W;
  localparam int NUM_W  = (NUM_W0 > PERIOD_W) ? NUM_W0 : PERIOD_W;
  localparam int DEN_W0 = (COUNT_BITS + 1 > AVG_W + 1) ? COUNT_BITS + 1 : AVG_W + 1;
  localparam int DEN_W  = (DEN_W0 > TEMPO_W) ? DEN_W0 : TEMPO_W;
  localparam int STEP_W = $clog2(NUM_W + 1);
  localparam int MCNT_W = $clog2(COUNT_BITS + 1);

  typedef struct packed {
    logic              start;
    logic [NUM_W-1:0]  dividend;  // left aligned: the MSB of the value at NUM_W-1
    logic [DEN_W-1:0]  divisor;
    logic [STEP_W-1:0] steps;     // quotient bits to produce
  } tte_div_req_t;

  typedef struct packed {
    logic             done;
    logic [NUM_W-1:0] quotient;
  } tte_div_rsp_t;

  typedef struct packed {
    logic                  start;
    logic [AVG_W-1:0]      mcand;
    logic [COUNT_BITS-1:0] mplier;
  } tte_mul_req_t;

  typedef struct packed {
    logic              done;
    logic [PROD_W-1:0] product;
  } tte_mul_rsp_t;

endpackage

### rtl/tte_serial_mul.sv
// Bit-serial shift-and-add multiplier, one multiplier bit per cycle.
// Depends on tte_pkg for widths and the request/response structs.
module tte_serial_mul
  import tte_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  tte_mul_req_t req_i,
  output tte_mul_rsp_t rsp_o
);

  logic                  busy_q, busy_d;
  logic                  done_q, done_d;
  logic [MCNT_W-1:0]     cnt_q, cnt_d;
  logic [PROD_W-1:0]     acc_q, acc_d;
  logic [PROD_W-1:0]     mcand_q, mcand_d;
  logic [COUNT_BITS-1:0] mplier_q, mplier_d;

  always_comb begin
    busy_d   = busy_q;
    done_d   = 1'b0;
    cnt_d    = cnt_q;
    acc_d    = acc_q;
    mcand_d  = mcand_q;
    mplier_d = mplier_q;
    if (req_i.start) begin
      busy_d   = 1'b1;
      cnt_d    = MCNT_W'(COUNT_BITS);
      acc_d    = '0;
      mcand_d  = PROD_W'(req_i.mcand);
      mplier_d = req_i.mplier;
    end else if (busy_q) begin
      if (mplier_q[0]) begin
        acc_d = acc_q + mcand_q;
      end
      mcand_d  = mcand_q << 1;
      mplier_d = mplier_q >> 1;
      cnt_d    = cnt_q - MCNT_W'(1);
      if (cnt_q == MCNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q    <= acc_d;
    mcand_q  <= mcand_d;
    mplier_q <= mplier_d;
  end

  assign rsp_o.done    = done_q;
  assign rsp_o.product = acc_q;

endmodule

### rtl/tte_serial_div.sv
// Restoring divider that produces one quotient bit per cycle, shared by all divisions.
// Depends on tte_pkg for widths and the request/response structs.
module tte_serial_div
  import tte_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  tte_div_req_t req_i,
  output tte_div_rsp_t rsp_o
);

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [STEP_W-1:0] cnt_q, cnt_d;
  logic [DEN_W-1:0]  rem_q, rem_d;
  logic [DEN_W-1:0]  den_q, den_d;
  logic [NUM_W-1:0]  dq_q, dq_d;
  logic [DEN_W:0]    trial;
  logic              fits;

  // The dividend shifts out at the top while quotient bits shift in at the bottom.
  assign trial = {rem_q, dq_q[NUM_W-1]};
  assign fits  = trial >= {1'b0, den_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    den_d  = den_q;
    dq_d   = dq_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = req_i.steps;
      rem_d  = '0;
      den_d  = req_i.divisor;
      dq_d   = req_i.dividend;
    end else if (busy_q) begin
      rem_d = fits ? DEN_W'(trial - {1'b0, den_q}) : trial[DEN_W-1:0];
      dq_d  = {dq_q[NUM_W-2:0], fits};
      cnt_d = cnt_q - STEP_W'(1);
      if (cnt_q == STEP_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    den_q <= den_d;
    dq_q  <= dq_d;
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = dq_q;

endmodule

### rtl/tap_tempo_estimator.sv
// Top level of the tap tempo estimator: tap handshake, running average control and output.
// Depends on tte_pkg, tte_serial_mul, tte_serial_div and the assertion macro header.
//
// Each accepted item is one tap timestamp in ms. A tap whose interval to the previous tap
// falls outside the configured window, or that only seeds the average, is taken while
// the block is idle and yields no result. Any other tap yields one result item: the
// bit-serial multiplier forms average * count, then one shared restoring divider, one
// quotient bit per cycle, computes the new average, the rounded tempo and the beat
// period in turn. No new tap is taken while that sequence runs; a finished result
// waits in an output register, so the next tap is taken while it is not yet collected.
`include "tap_tempo_estimator_macros.svh"

module tap_tempo_estimator
  import tte_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // tap_time_ms [31:0]
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // tempo_bpm [11:0], beat_period_ms [27:12], taps_averaged [43:28], zero fill [47:44]
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  input  logic                   cfg_we_i,
  input  logic [CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [REG_W-1:0]       cfg_wdata_i
);

  typedef enum logic [5:0] {
    S_IDLE       = 6'b000001,
    S_MUL        = 6'b000010,
    S_DIV_AVG    = 6'b000100,
    S_DIV_TEMPO  = 6'b001000,
    S_DIV_PERIOD = 6'b010000,
    S_OUT        = 6'b100000
  } tte_state_e;

  tte_state_e state_q, state_d;

  logic [REG_W-1:0]      min_q, max_q;
  logic [TIME_W-1:0]     last_q, last_d;
  logic [AVG_W-1:0]      avg_q, avg_d;
  logic [COUNT_BITS-1:0] count_q, count_d;
  logic [AVG_W-1:0]      scaled_q, scaled_d;
  logic [TEMPO_W-1:0]    bpm_q, bpm_d;
  logic [PERIOD_W-1:0]   period_q, period_d;
  logic                  out_valid_q;
  logic [OUT_TDATA_W-1:0] out_data_q;
  logic                  out_load;

  logic                  in_acc;
  logic [TIME_W-1:0]     interval;
  logic                  in_window;
  logic [AVG_W-1:0]      scaled;
  logic [SUM_W-1:0]      sum;
  logic [AVG_W-1:0]      new_avg;
  logic [TNUM_W-1:0]     tnum;
  logic [TNUM_W-1:0]     tquot;
  logic [TAPS_W-1:0]     taps;

  tte_mul_req_t mul_req;
  tte_mul_rsp_t mul_rsp;
  tte_div_req_t div_req;
  tte_div_rsp_t div_rsp;

  tte_serial_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mul_req),
    .rsp_o  (mul_rsp)
  );

  tte_serial_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign s_axis_tready = (state_q == S_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  // Unsigned subtraction gives the interval modulo 2^32 across a timestamp wrap.
  assign interval  = s_axis_tdata[TIME_W-1:0] - last_q;
  assign in_window = (interval < TIME_W'(max_q)) && (interval > TIME_W'(min_q));
  assign scaled    = AVG_W'(interval[REG_W-1:0]) << FRACTION_BITS;

  assign sum     = SUM_W'(mul_rsp.product) + SUM_W'(scaled_q);
  assign new_avg = div_rsp.quotient[AVG_W-1:0];
  assign tnum    = TNUM_W'(TNUM_BASE) + TNUM_W'(new_avg);
  assign tquot   = div_rsp.quotient[TNUM_W-1:0];

  always_comb begin
    state_d  = state_q;
    last_d   = last_q;
    avg_d    = avg_q;
    count_d  = count_q;
    scaled_d = scaled_q;
    bpm_d    = bpm_q;
    period_d = period_q;
    out_load = 1'b0;

    mul_req.start  = 1'b0;
    mul_req.mcand  = avg_q;
    mul_req.mplier = count_q;

    div_req.start    = 1'b0;
    div_req.dividend = '0;
    div_req.divisor  = '0;
    div_req.steps    = '0;

    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          last_d = s_axis_tdata[TIME_W-1:0];
          if (!in_window) begin
            count_d = '0;
          end else if (count_q == '0) begin
            avg_d   = scaled;
            count_d = COUNT_BITS'(1);
          end else begin
            scaled_d      = scaled;
            mul_req.start = 1'b1;
            state_d       = S_MUL;
          end
        end
      end
      S_MUL: begin
        if (mul_rsp.done) begin
          div_req.start    = 1'b1;
          div_req.dividend = NUM_W'(sum) << (NUM_W - SUM_W);
          div_req.divisor  = DEN_W'({1'b0, count_q} + (COUNT_BITS + 1)'(1));
          div_req.steps    = STEP_W'(SUM_W);
          state_d          = S_DIV_AVG;
        end
      end
      S_DIV_AVG: begin
        if (div_rsp.done) begin
          avg_d = new_avg;
          if (count_q != COUNT_MAX) begin
            count_d = count_q + COUNT_BITS'(1);
          end
          // A zero divisor would give an all-ones quotient, which saturates to the maximum tempo.
          div_req.start    = 1'b1;
          div_req.dividend = NUM_W'(tnum) << (NUM_W - TNUM_W);
          div_req.divisor  = DEN_W'({new_avg, 1'b0});
          div_req.steps    = STEP_W'(TNUM_W);
          state_d          = S_DIV_TEMPO;
        end
      end
      S_DIV_TEMPO: begin
        if (div_rsp.done) begin
          if (64'(tquot) > TEMPO_MAX) begin
            bpm_d = TEMPO_W'(TEMPO_MAX);
          end else if (tquot == '0) begin
            bpm_d = TEMPO_W'(1);
          end else begin
            bpm_d = tquot[TEMPO_W-1:0];
          end
          div_req.start    = 1'b1;
          div_req.dividend = NUM_W'(PERIOD_W'(MS_PER_MINUTE)) << (NUM_W - PERIOD_W);
          div_req.divisor  = DEN_W'(bpm_d);
          div_req.steps    = STEP_W'(PERIOD_W);
          state_d          = S_DIV_PERIOD;
        end
      end
      S_DIV_PERIOD: begin
        if (div_rsp.done) begin
          period_d = div_rsp.quotient[PERIOD_W-1:0];
          state_d  = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_valid_q || m_axis_tready) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign taps = (64'(count_q) > TAPS_MAX) ? TAPS_W'(TAPS_MAX) : TAPS_W'(count_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      min_q       <= MIN_INTERVAL_RESET;
      max_q       <= MAX_INTERVAL_RESET;
      last_q      <= '0;
      avg_q       <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      last_q  <= last_d;
      avg_q   <= avg_d;
      count_q <= count_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_MIN_INTERVAL: min_q <= cfg_wdata_i;
          REG_MAX_INTERVAL: max_q <= cfg_wdata_i;
          default: begin
          end
        endcase
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    scaled_q <= scaled_d;
    bpm_q    <= bpm_d;
    period_q <= period_d;
    if (out_load) begin
      out_data_q <= OUT_TDATA_W'({taps, period_q, bpm_q});
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  // The multiplier reports only while the sequence waits for it.
  `TTE_ASSERT_IMPL(a_mul_done_in_mul, mul_rsp.done, state_q == S_MUL)
  // The divider reports only during one of the three divisions.
  `TTE_ASSERT_IMPL(a_div_done_in_div, div_rsp.done,
                   state_q == S_DIV_AVG || state_q == S_DIV_TEMPO || state_q == S_DIV_PERIOD)
  // An update always averages with a seeded, nonzero count.
  `TTE_ASSERT_IMPL(a_count_seeded, state_q == S_MUL, count_q != '0)
  // A loaded result leaves the output register valid on the next edge.
  `TTE_ASSERT(a_out_loaded, out_load |=> m_axis_tvalid)

endmodule
